### design/espf_pkg.sv
// ----------------------------------------------------------------------------
// espf_pkg
// Shared types and constants for the ellipse span filler.
// ----------------------------------------------------------------------------
package espf_pkg;

    localparam int COORD_BITS = 10;
    localparam int SIZE_W     = 6;
    localparam int OUT_W      = 11;
    localparam int MUL_W      = 12;               // multiplier operand width
    localparam int PROD_W     = 26;               // unsigned squared terms
    localparam int SQ_W       = PROD_W + 1;       // signed squared terms
    localparam int LIN_W      = 21;               // signed linear terms
    localparam int Y_W        = COORD_BITS + 3;   // signed doubled row cursor
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    typedef struct packed {
        logic [COORD_BITS-1:0] box_left;
        logic [COORD_BITS-1:0] box_top;
        logic [SIZE_W-1:0]     box_width;
        logic [SIZE_W-1:0]     box_height;
    } box_t;

    typedef struct packed {
        logic [OUT_W-1:0] line_x;
        logic [OUT_W-1:0] line_top;
        logic [OUT_W-1:0] line_bottom;
        logic             last_line;
    } span_t;

    // One classified box, handed from the front to the back.
    typedef struct packed {
        logic [COORD_BITS-1:0]   bx;
        logic [COORD_BITS-1:0]   by;
        logic [SIZE_W-1:0]       w;
        logic [SIZE_W-1:0]       h;
        logic                    empty_shape;
        logic [MUL_W-1:0]        w2;
        logic [MUL_W-1:0]        h2;
        logic [PROD_W-1:0]       whsq;
        logic [PROD_W-1:0]       a0;
        logic signed [LIN_W-1:0] r0;
    } job_t;

endpackage

### design/espf_front.sv
// ----------------------------------------------------------------------------
// espf_front
// Accepts a box, saturates its size and computes the squared terms of the
// ellipse test on one shared multiplier, then pushes the job to the queue.
// ----------------------------------------------------------------------------
module espf_front
    import espf_pkg::*;
#(
    parameter int MAX_SIZE = 62
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  box_t box,
    input  logic q_full,
    output logic q_push,
    output job_t q_data
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_WW,
        F_HH,
        F_DD,
        F_WH,
        F_A0,
        F_R0,
        F_PUSH
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [COORD_BITS-1:0]   bx_reg, by_reg;
    logic [SIZE_W-1:0]       w_reg, h_reg;
    logic [MUL_W-1:0]        w2_reg, h2_reg, dd_reg;
    logic [PROD_W-1:0]       whsq_reg, a0_reg;
    logic signed [LIN_W-1:0] r0_reg;

    logic [SIZE_W-1:0]       w_sat, h_sat, dm;
    logic [MUL_W-1:0]        op_a, op_b;
    logic [2*MUL_W-1:0]      prod;
    logic signed [LIN_W-1:0] r_mag;
    logic                    accept;

    assign accept = start && (state_reg == F_IDLE);
    assign busy   = (state_reg != F_IDLE);

    assign w_sat = (box.box_width > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : box.box_width;
    assign h_sat = (box.box_height > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : box.box_height;

    // |1 - w|
    assign dm = (w_reg == '0) ? SIZE_W'(1) : w_reg - SIZE_W'(1);

    always_comb
    begin
        unique case (state_reg)
            F_WW:
            begin
                op_a = MUL_W'(w_reg);
                op_b = MUL_W'(w_reg);
            end
            F_HH:
            begin
                op_a = MUL_W'(h_reg);
                op_b = MUL_W'(h_reg);
            end
            F_DD:
            begin
                op_a = MUL_W'(dm);
                op_b = MUL_W'(dm);
            end
            F_WH:
            begin
                op_a = w2_reg;
                op_b = h2_reg;
            end
            F_A0:
            begin
                op_a = dd_reg;
                op_b = h2_reg;
            end
            F_R0:
            begin
                op_a = MUL_W'(dm);
                op_b = h2_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod  = op_a * op_b;
    assign r_mag = $signed({1'b0, prod[LIN_W-2:0]});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (start) state_next = F_WW;
            F_WW:   state_next = F_HH;
            F_HH:   state_next = F_DD;
            F_DD:   state_next = F_WH;
            F_WH:   state_next = F_A0;
            F_A0:   state_next = F_R0;
            F_R0:   state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bx_reg <= box.box_left;
            by_reg <= box.box_top;
            w_reg  <= w_sat;
            h_reg  <= h_sat;
        end
        unique case (state_reg)
            F_WW:    w2_reg   <= prod[MUL_W-1:0];
            F_HH:    h2_reg   <= prod[MUL_W-1:0];
            F_DD:    dd_reg   <= prod[MUL_W-1:0];
            F_WH:    whsq_reg <= PROD_W'(prod);
            F_A0:    a0_reg   <= PROD_W'(prod);
            F_R0:    r0_reg   <= (w_reg == '0) ? r_mag : -r_mag;
            default: ;
        endcase
    end

    assign q_push = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        q_data.bx          = bx_reg;
        q_data.by          = by_reg;
        q_data.w           = w_reg;
        q_data.h           = h_reg;
        q_data.empty_shape = (w_reg == '0) || (h_reg == '0);
        q_data.w2          = w2_reg;
        q_data.h2          = h2_reg;
        q_data.whsq        = whsq_reg;
        q_data.a0          = a0_reg;
        q_data.r0          = r0_reg;
    end

endmodule

### design/espf_queue.sv
// ----------------------------------------------------------------------------
// espf_queue
// Short FIFO of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module espf_queue
    import espf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/espf_back.sv
// ----------------------------------------------------------------------------
// espf_back
// Walks the columns of one job, moves the row cursor up with incremental
// squared terms and emits the segment and its mirror for each column.
// ----------------------------------------------------------------------------
module espf_back
    import espf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_empty,
    input  job_t  q_head,
    output logic  q_pop,
    output logic  span_strobe,
    output span_t span
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_TEST,
        B_MIRROR
    } bstate_t;

    bstate_t state_reg, state_next;

    logic [OUT_W-1:0]        x_reg;
    logic [SIZE_W-2:0]       col_reg, last_col_reg;
    logic                    empty_shape_reg;
    logic [MUL_W-1:0]        w2_reg, h2_reg;
    logic [PROD_W-1:0]       whsq_reg;
    logic signed [SQ_W-1:0]  a_reg, q_reg;
    logic signed [LIN_W-1:0] r_reg, p_reg;
    logic signed [Y_W-1:0]   y_reg;
    logic [Y_W-1:0]          base_reg;
    logic [OUT_W:0]          mir_reg;

    logic signed [SQ_W:0]    sum_aq;
    logic                    in_shape;
    logic [OUT_W-1:0]        top_val, bottom_val, mirror_x;
    logic signed [Y_W:0]     diff;
    logic [OUT_W:0]          mirror_full;
    logic signed [SQ_W-1:0]  w2_sq, h2_sq, p_sq, r_sq;
    logic                    last_col;

    assign sum_aq   = {a_reg[SQ_W-1], a_reg} + {q_reg[SQ_W-1], q_reg};
    assign in_shape = !empty_shape_reg && (sum_aq <= $signed({2'b00, whsq_reg}));

    assign top_val     = y_reg[Y_W-1] ? '0 : y_reg[OUT_W:1];
    assign diff        = $signed({1'b0, base_reg}) - $signed({y_reg[Y_W-1], y_reg});
    assign bottom_val  = diff[OUT_W:1];
    assign mirror_full = mir_reg - {1'b0, x_reg};
    assign mirror_x    = mirror_full[OUT_W-1:0];
    assign last_col    = (col_reg == last_col_reg);

    assign w2_sq = $signed({{(SQ_W-MUL_W){1'b0}}, w2_reg});
    assign h2_sq = $signed({{(SQ_W-MUL_W){1'b0}}, h2_reg});
    assign p_sq  = {{(SQ_W-LIN_W){p_reg[LIN_W-1]}}, p_reg};
    assign r_sq  = {{(SQ_W-LIN_W){r_reg[LIN_W-1]}}, r_reg};

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (!q_empty) state_next = B_TEST;
            B_TEST:   if (!in_shape) state_next = B_MIRROR;
            B_MIRROR: state_next = last_col ? B_IDLE : B_TEST;
            default:  state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            span_strobe <= 1'b0;
            span        <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            span_strobe <= 1'b0;
            if (state_reg == B_TEST && !in_shape)
            begin
                span_strobe      <= 1'b1;
                span.line_x      <= x_reg;
                span.line_top    <= top_val;
                span.line_bottom <= bottom_val;
                span.last_line   <= 1'b0;
            end
            else if (state_reg == B_MIRROR)
            begin
                span_strobe      <= 1'b1;
                span.line_x      <= mirror_x;
                span.line_top    <= top_val;
                span.line_bottom <= bottom_val;
                span.last_line   <= last_col;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    x_reg           <= {1'b0, q_head.bx};
                    col_reg         <= '0;
                    last_col_reg    <= q_head.w[SIZE_W-1:1];
                    empty_shape_reg <= q_head.empty_shape;
                    w2_reg          <= q_head.w2;
                    h2_reg          <= q_head.h2;
                    whsq_reg        <= q_head.whsq;
                    a_reg           <= $signed({1'b0, q_head.a0});
                    r_reg           <= q_head.r0;
                    // candidate dy starts at -1
                    q_reg           <= $signed({{(SQ_W-MUL_W){1'b0}}, q_head.w2});
                    p_reg           <= -$signed({{(LIN_W-MUL_W){1'b0}}, q_head.w2});
                    y_reg           <= $signed({2'b00, q_head.by, 1'b0})
                                       + $signed({{(Y_W-SIZE_W){1'b0}}, q_head.h});
                    base_reg        <= {1'b0, q_head.by, 2'b00}
                                       + {{(Y_W-SIZE_W-1){1'b0}}, q_head.h, 1'b0};
                    mir_reg         <= {1'b0, q_head.bx, 1'b0}
                                       + {{(OUT_W+1-SIZE_W){1'b0}}, q_head.w};
                end
            end
            B_TEST:
            begin
                // step the cursor up one row while the next pixel is inside
                if (in_shape)
                begin
                    y_reg <= y_reg - Y_W'(2);
                    q_reg <= q_reg - (p_sq <<< 2) + (w2_sq <<< 2);
                    p_reg <= p_reg - LIN_W'(w2_sq <<< 1);
                end
            end
            B_MIRROR:
            begin
                // advance to the next column: dx grows by two
                x_reg   <= x_reg + 1'b1;
                col_reg <= col_reg + 1'b1;
                a_reg   <= a_reg + (r_sq <<< 2) + (h2_sq <<< 2);
                r_reg   <= r_reg + LIN_W'(h2_sq <<< 1);
            end
            default: ;
        endcase
    end

endmodule

### design/ellipse_span_filler_unit.sv
// ----------------------------------------------------------------------------
// ellipse_span_filler_unit
// Fills the ellipse inscribed in a box with vertical segments, two per
// column from the left edge to the center.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  box in    start / busy           box   (box_t)
//  span out  span_strobe, 1 cycle   span  (span_t)
//
//  The front computes its products in turn on its single 12x12 multiplier, then
//  hands the box to a two-entry queue, waiting while the queue is full. The back
//  loads a job, then for each column steps the cursor up one row at a time while
//  the next pixel is inside and emits the segment and its mirror.
//  Reset clears all control state; no clearing pass is needed.
//  Segments cannot be stalled; busy drops once the front hands off its box.
// ----------------------------------------------------------------------------
module ellipse_span_filler_unit
    import espf_pkg::*;
#(
    parameter int MAX_SIZE = 62
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  box_t  box,
    output logic  span_strobe,
    output span_t span
);

    logic q_full, q_push, q_pop, q_empty;
    job_t q_data, q_head;

    espf_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .box    (box),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    espf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    espf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .span_strobe (span_strobe),
        .span        (span)
    );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ellipse_span_filler_unit. Boxes go in through the
// start/busy handshake. A local model of the column walk predicts every span
// per box, and a monitor compares each strobed span with the oldest
// prediction. Directed boxes come first, then random boxes under several
// sender idle rates.
// ----------------------------------------------------------------------------
module tb
    import espf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOX_MAX     = 62;
    localparam int ROW_LIMIT   = 2 * BOX_MAX + 4;
    localparam int DRAIN_TAIL  = 150;
    localparam int REPORT_MAX  = 10;

    logic  clk;
    logic  rst_n       = 1'b0;
    logic  start       = 1'b0;
    box_t  box         = '0;
    logic  busy;
    logic  span_strobe;
    span_t span;

    span_t pending_spans[$];
    int    error_count = 0;
    int    idle_pct    = 0;

    ellipse_span_filler_unit #(
        .MAX_SIZE (BOX_MAX)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .box         (box),
        .span_strobe (span_strobe),
        .span        (span)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bit in_ellipse(longint dx, longint dy, longint w, longint h);
        if (w <= 0 || h <= 0)
            return 1'b0;
        return dx * dx * h * h + dy * dy * w * w <= w * w * h * h;
    endfunction

    // Walk the columns left edge to center; the doubled row cursor carries
    // over from column to column.
    function automatic void predict_spans(box_t b);
        longint bx, by, w, h, cx, cy, yd, col, last_col, dx, mirror, upper, lower;
        int     steps;
        span_t  s;
        bx = b.box_left;
        by = b.box_top;
        w  = b.box_width;
        h  = b.box_height;
        if (w > BOX_MAX)
            w = BOX_MAX;
        if (h > BOX_MAX)
            h = BOX_MAX;
        cx       = 2 * bx + w;
        cy       = 2 * by + h;
        yd       = cy;
        last_col = bx + w / 2;
        for (col = bx; col <= last_col; col++)
        begin
            dx    = 2 * col + 1 - cx;
            steps = 0;
            do
            begin
                yd -= 2;
                steps++;
            end
            while (steps < ROW_LIMIT && in_ellipse(dx, yd + 1 - cy, w, h));
            yd += 2;
            upper  = yd / 2;
            lower  = (4 * by + 2 * h - yd) >>> 1;
            mirror = 2 * bx + w - col;
            s.line_x      = OUT_W'(col);
            s.line_top    = OUT_W'(upper);
            s.line_bottom = OUT_W'(lower);
            s.last_line   = 1'b0;
            pending_spans.push_back(s);
            s.line_x    = OUT_W'(mirror);
            s.last_line = (col == last_col);
            pending_spans.push_back(s);
        end
    endfunction

    function automatic box_t make_box(int left, int top, int w, int h);
        box_t b;
        b.box_left   = COORD_BITS'(left);
        b.box_top    = COORD_BITS'(top);
        b.box_width  = SIZE_W'(w);
        b.box_height = SIZE_W'(h);
        return b;
    endfunction

    // Hold start and the box until busy is low at an edge, then idle at random.
    task automatic send_box(box_t b);
        start <= 1'b1;
        box   <= b;
        do
            @(posedge clk);
        while (busy);
        predict_spans(b);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_spans.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extreme_boxes();
        send_box(make_box(0, 0, 1, 1));
        send_box(make_box(1023, 1023, 62, 62));
        send_box(make_box(0, 0, 62, 62));
        send_box(make_box(1023, 1023, 1, 62));
        send_box(make_box(512, 341, 62, 1));
        // mirror overshoot past the 10-bit coordinate range
        send_box(make_box(1023, 0, 62, 62));
        send_box(make_box(682, 1023, 31, 45));
    endtask

    task automatic test_degenerate_boxes();
        send_box(make_box(10, 20, 0, 7));
        send_box(make_box(100, 200, 9, 0));
        send_box(make_box(0, 0, 0, 0));
        send_box(make_box(1023, 1023, 0, 0));
    endtask

    task automatic test_oversized_boxes();
        send_box(make_box(300, 400, 63, 40));
        send_box(make_box(5, 6, 17, 63));
        send_box(make_box(1023, 1023, 63, 63));
    endtask

    // Odd heights at the top border drive the cursor to doubled row -1.
    task automatic test_top_border();
        send_box(make_box(0, 0, 5, 3));
        send_box(make_box(7, 0, 20, 11));
        send_box(make_box(0, 0, 2, 1));
    endtask

    task automatic test_random_boxes(int pct, int count);
        idle_pct = pct;
        repeat (count)
            send_box(make_box($urandom_range(1023), $urandom_range(1023),
                              $urandom_range(63), $urandom_range(63)));
    endtask

    always @(posedge clk)
    begin
        span_t want;
        if (rst_n && span_strobe)
        begin
            if (pending_spans.size() == 0)
            begin
                if (error_count < REPORT_MAX)
                    $display("unexpected span: x=%0d top=%0d bottom=%0d last=%0d",
                             span.line_x, span.line_top, span.line_bottom,
                             span.last_line);
                error_count++;
            end
            else
            begin
                want = pending_spans.pop_front();
                if (span !== want)
                begin
                    if (error_count < REPORT_MAX)
                    begin
                        $display("span mismatch: expected x=%0d top=%0d bottom=%0d last=%0d",
                                 want.line_x, want.line_top, want.line_bottom,
                                 want.last_line);
                        $display("               got      x=%0d top=%0d bottom=%0d last=%0d",
                                 span.line_x, span.line_top, span.line_bottom,
                                 span.last_line);
                    end
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_boxes();
        test_degenerate_boxes();
        test_oversized_boxes();
        test_top_border();
        wait_drained();

        test_random_boxes(0, 35);
        wait_drained();
        test_random_boxes(86, 35);
        test_random_boxes(34, 35);

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (error_count == 0 && pending_spans.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
design/espf_pkg.sv
design/espf_front.sv
design/espf_queue.sv
design/espf_back.sv
design/ellipse_span_filler_unit.sv
test/tb.sv
